// ----- rtl/brute_force_radius_search_defines.svh -----
// assertion macros shared by the search block
`ifndef BRUTE_FORCE_RADIUS_SEARCH_DEFINES_SVH
`define BRUTE_FORCE_RADIUS_SEARCH_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BRFRS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define BRFRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/brfrs_pkg.sv -----
package brfrs_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS_DEF   = 32;

  // fixed field widths
  localparam int COORD_W    = 16;
  localparam int DIST_W     = 40;
  localparam int IDX_W      = 6;
  localparam int LANE_W     = 6;
  localparam int DIM_CFG_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // request commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METRIC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_IDX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_DIST = 3'd4;

  // token moving down the cell chain, one per stored point (one with pt low for an empty store)
  typedef struct packed {
    logic             vld;   // slot occupied
    logic             pt;    // carries a real point (empty store sends none)
    logic             last;  // final token of this query
    logic [IDX_W-1:0] idx;   // point row
  } tok_t;

  // coordinate write broadcast to every cell
  typedef struct packed {
    logic               ld_en;  // reference coordinate write
    logic               q_en;   // query coordinate write
    logic               first;  // first coordinate: zero the rest of the row
    logic [LANE_W-1:0]  lane;
    logic [IDX_W-1:0]   row;
    logic [COORD_W-1:0] data;
  } wr_t;

endpackage

// ----- rtl/brfrs_cell.sv -----
module brfrs_cell #(
  parameter int MAX_POINTS = brfrs_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = brfrs_pkg::MAX_DIMS_DEF,
  parameter int LANE       = 0,
  parameter int DW         = $clog2(MAX_DIMS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        metric,
  input  logic [DW-1:0]               eff_d,
  input  brfrs_pkg::wr_t              wr,
  input  brfrs_pkg::tok_t             tok_in,
  input  logic [brfrs_pkg::DIST_W-1:0] acc_in,
  output brfrs_pkg::tok_t             tok_out,
  output logic [brfrs_pkg::DIST_W-1:0] acc_out
);
  import brfrs_pkg::*;

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // one coordinate column of the point store and one query coordinate
  logic [COORD_W-1:0] mem [MAX_POINTS];
  logic [COORD_W-1:0] q;
  logic [COORD_W-1:0] rdata;
  logic               lane_hit;

  tok_t              a_tok;
  logic [DIST_W-1:0] a_acc;

  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        mag17;
  logic [COORD_W-1:0]      mag;
  logic [2*COORD_W-1:0]    sq;
  logic [DIST_W-1:0]       term;

  assign lane_hit = (wr.lane == LANE_W'(LANE));

  // column write and registered read
  always_ff @(posedge clk) begin
    if (wr.ld_en && (lane_hit || wr.first)) begin
      mem[wr.row[PW-1:0]] <= lane_hit ? wr.data : '0;
    end
    if (adv) begin
      rdata <= mem[tok_in.idx[PW-1:0]];
    end
  end

  // query coordinate held for the whole evaluation
  always_ff @(posedge clk) begin
    if (wr.q_en && (lane_hit || wr.first)) begin
      q <= lane_hit ? wr.data : '0;
    end
  end

  // first stage: wait for the column read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok <= '0;
    end else if (adv) begin
      a_tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_acc <= acc_in;
    end
  end

  // distance term for this coordinate
  always_comb begin
    diff  = $signed({q[COORD_W-1], q}) - $signed({rdata[COORD_W-1], rdata});
    mag17 = diff[COORD_W] ? 17'(-diff) : 17'(diff);
    mag   = mag17[COORD_W-1:0];
    sq    = mag * mag;
    if (DW'(LANE) >= eff_d) begin
      term = '0;
    end else if (metric) begin
      term = DIST_W'(sq);
    end else begin
      term = DIST_W'(mag);
    end
  end

  // second stage: add to the running sum and hand on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= a_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_out <= a_acc + term;
    end
  end

endmodule

// ----- rtl/brfrs_out.sv -----
module brfrs_out (
  input  logic                          clk,
  input  logic                          rst,
  input  brfrs_pkg::tok_t               tail,
  input  logic [brfrs_pkg::DIST_W-1:0]  tail_acc,
  input  logic [brfrs_pkg::DIST_W-1:0]  radius_raw,
  input  logic                          report_index,
  input  logic                          report_distance,
  output logic                          adv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [brfrs_pkg::IDX_W-1:0]   point_index,
  output logic [brfrs_pkg::DIST_W-1:0]  raw_dist,
  output logic                          last
);
  import brfrs_pkg::*;

  // one match held back until we know whether it is the final one
  logic              pend_v;
  logic [IDX_W-1:0]  pend_idx;
  logic [DIST_W-1:0] pend_dist;
  logic              done;
  logic              hit;

  // chain moves only when the output register is free or being taken
  assign adv = !out_valid || out_ready;
  assign hit = tail.vld && tail.pt && (tail_acc <= radius_raw);

  // output valid and held-match bookkeeping; out_valid only changes on adv
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      done      <= 1'b0;
    end else if (adv) begin
      if (hit) begin
        // new match pushes the held one out
        out_valid <= pend_v;
        pend_v    <= 1'b1;
        if (tail.last) begin
          done <= 1'b1;
        end
      end else if (tail.vld) begin
        out_valid <= 1'b0;
        if (tail.last) begin
          done <= 1'b1;
        end
      end else if (done) begin
        // flush held match as final, or report nothing found
        out_valid <= 1'b1;
        pend_v    <= 1'b0;
        done      <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (hit) begin
        if (pend_v) begin
          found       <= 1'b1;
          point_index <= pend_idx;
          raw_dist    <= pend_dist;
          last        <= 1'b0;
        end
        pend_idx  <= report_index ? tail.idx : '0;
        pend_dist <= report_distance ? tail_acc : '0;
      end else if (!tail.vld && done) begin
        found       <= pend_v;
        point_index <= pend_v ? pend_idx : '0;
        raw_dist    <= pend_v ? pend_dist : '0;
        last        <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/brute_force_radius_search.sv -----
// Fixed-radius neighbor search over up to MAX_POINTS stored points of
// dims_in_use Q8.8 coordinates. A query request that completes its vector
// starts an evaluation: one point token enters a chain of MAX_DIMS cells per
// cycle while the chain is not halted, each cell owning one coordinate
// column of the point store; the chain halts while a result waits on
// out_ready. No new request is taken until the final result of a query has
// been delivered. Matches come out in load order with raw L1 or squared-L2
// distances; an empty or unmatched query gives one result with found low.
`include "brute_force_radius_search_defines.svh"

module brute_force_radius_search #(
  parameter int MAX_POINTS = brfrs_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = brfrs_pkg::MAX_DIMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [brfrs_pkg::COORD_W-1:0] coord,
  input  logic                              end_of_vector,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [brfrs_pkg::IDX_W-1:0]       point_index,
  output logic [brfrs_pkg::DIST_W-1:0]      raw_dist,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [brfrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brfrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brfrs_pkg::*;

  localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int LW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW  = $clog2(MAX_DIMS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic                 metric;
  logic [DIM_CFG_W-1:0] dims_in_use;
  logic [DIST_W-1:0]    radius_raw;
  logic                 report_index;
  logic                 report_distance;

  // load and query bookkeeping
  logic [PCW-1:0] points_loaded;
  logic [LW-1:0]  load_pos;
  logic [LW-1:0]  query_pos;
  logic [PW-1:0]  cnt;

  logic [DW-1:0]  eff_d;
  logic [DIM_CFG_W:0] dims_ext;
  logic           in_fire;
  logic           full;
  logic [LW-1:0]  lp;
  logic [LW-1:0]  qp;
  logic [DW-1:0]  lp1;
  logic [DW-1:0]  qp1;
  logic           ld_done;
  logic           q_done;
  logic           adv;
  logic           issue_last;
  wr_t            wr;

  tok_t              tok_c [MAX_DIMS+1];
  logic [DIST_W-1:0] acc_c [MAX_DIMS+1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      metric          <= 1'b1;
      dims_in_use     <= DIM_CFG_W'(32);
      radius_raw      <= '0;
      report_index    <= 1'b1;
      report_distance <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METRIC:      metric          <= cfg_data[0];
        REG_DIMS:        dims_in_use     <= cfg_data[DIM_CFG_W-1:0];
        REG_RADIUS:      radius_raw      <= cfg_data[DIST_W-1:0];
        REG_REPORT_IDX:  report_index    <= cfg_data[0];
        REG_REPORT_DIST: report_distance <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective vector length: zero acts as one, clipped to the chain length
  always_comb begin
    dims_ext = {1'b0, dims_in_use};
    if (dims_in_use == '0) begin
      eff_d = DW'(1);
    end else if (dims_ext > (DIM_CFG_W+1)'(MAX_DIMS)) begin
      eff_d = DW'(MAX_DIMS);
    end else begin
      eff_d = DW'(dims_ext);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (points_loaded >= PCW'(MAX_POINTS));

  // positions restart when the vector length shrank under them
  assign lp      = (DW'(load_pos) >= eff_d) ? '0 : load_pos;
  assign qp      = (DW'(query_pos) >= eff_d) ? '0 : query_pos;
  assign lp1     = DW'(lp) + DW'(1);
  assign qp1     = DW'(qp) + DW'(1);
  assign ld_done = end_of_vector || (lp1 >= eff_d);
  assign q_done  = end_of_vector || (qp1 >= eff_d);

  // coordinate write broadcast
  always_comb begin
    wr       = '0;
    wr.data  = coord;
    wr.row   = IDX_W'(points_loaded);
    if (in_fire && (cmd == CMD_LOAD) && !full) begin
      wr.ld_en = 1'b1;
      wr.first = (lp == '0);
      wr.lane  = LANE_W'(lp);
    end else if (in_fire && (cmd == CMD_QUERY)) begin
      wr.q_en  = 1'b1;
      wr.first = (qp == '0);
      wr.lane  = LANE_W'(qp);
    end
  end

  // store and query counters
  always_ff @(posedge clk) begin
    if (rst) begin
      points_loaded <= '0;
      load_pos      <= '0;
      query_pos     <= '0;
    end else if (in_fire) begin
      if (cmd == CMD_CLEAR) begin
        points_loaded <= '0;
        load_pos      <= '0;
      end else if (cmd == CMD_LOAD && !full) begin
        if (ld_done) begin
          points_loaded <= points_loaded + PCW'(1);
          load_pos      <= '0;
        end else begin
          load_pos <= LW'(lp1);
        end
      end else if (cmd == CMD_QUERY) begin
        query_pos <= q_done ? '0 : LW'(qp1);
      end
    end
  end

  // token entering the chain
  assign issue_last = (points_loaded == '0) || ((PCW'(cnt) + PCW'(1)) == points_loaded);

  always_comb begin
    tok_c[0]      = '0;
    tok_c[0].vld  = (state == S_ISSUE);
    tok_c[0].pt   = (points_loaded != '0);
    tok_c[0].last = issue_last;
    tok_c[0].idx  = IDX_W'(cnt);
    acc_c[0]      = '0;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (cmd == CMD_QUERY) && q_done) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (adv && issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_valid && out_ready && last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        cnt <= '0;
      end else if (state == S_ISSUE && adv) begin
        cnt <= cnt + PW'(1);
      end
    end
  end

  // one cell per coordinate
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
    brfrs_cell #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS),
      .LANE       (j),
      .DW         (DW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .metric  (metric),
      .eff_d   (eff_d),
      .wr      (wr),
      .tok_in  (tok_c[j]),
      .acc_in  (acc_c[j]),
      .tok_out (tok_c[j+1]),
      .acc_out (acc_c[j+1])
    );
  end

  // threshold compare and result ordering
  brfrs_out u_out (
    .clk             (clk),
    .rst             (rst),
    .tail            (tok_c[MAX_DIMS]),
    .tail_acc        (acc_c[MAX_DIMS]),
    .radius_raw      (radius_raw),
    .report_index    (report_index),
    .report_distance (report_distance),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .point_index     (point_index),
    .raw_dist        (raw_dist),
    .last            (last)
  );

  // checks
  `BRFRS_ASSERT_NOW(a_no_req_with_result, out_valid, !in_ready, "request taken while result pending")
  `BRFRS_ASSERT_NOW(a_miss_is_last, out_valid && !found, last, "not-found result not final")
  `BRFRS_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last, in_ready, "not idle after query")
  `BRFRS_ASSERT_NOW(a_tail_busy, tok_c[MAX_DIMS].vld, state != S_IDLE, "token in chain while idle")

endmodule
